[rtl/assert_macros.svh]
// Assertion macros for the RTL top level of the SGR escape filter.
// No dependencies; included by the top level, the only file that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[rtl/asef_pkg.sv]
// Shared types, constants and helper functions of the SGR escape filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package asef_pkg;

   localparam logic [7:0] ESC_CHAR      = 8'd27;
   localparam logic [7:0] BRACKET_CHAR  = 8'h5B;
   localparam logic [7:0] SEMI_CHAR     = 8'h3B;
   localparam logic [7:0] ZERO_CHAR     = 8'h30;
   localparam logic [7:0] NINE_CHAR     = 8'h39;
   localparam logic [7:0] M_CHAR        = 8'h6D;
   localparam logic [7:0] FG_TENS_CHAR  = 8'h33;
   localparam logic [7:0] BG_TENS_CHAR  = 8'h34;
   localparam logic [7:0] FINAL_LO      = 8'd64;
   localparam logic [7:0] FINAL_HI      = 8'd126;
   localparam logic [7:0] ACCUM_MAX     = 8'd255;
   localparam logic [7:0] STYLE_MAX     = 8'd4;
   localparam logic [7:0] FG_LO         = 8'd30;
   localparam logic [7:0] FG_HI         = 8'd37;
   localparam logic [7:0] BG_LO         = 8'd40;
   localparam logic [7:0] BG_HI         = 8'd47;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int NUM_SLOTS = 15;

   typedef enum logic [1:0] {
      MODE_TEXT      = 2'd0,
      MODE_AFTER_ESC = 2'd1,
      MODE_PARAMS    = 2'd2
   } parse_mode_type;

   // Byte positions of one expanded command, in output order.
   typedef enum logic [3:0] {
      SLOT_TEXT          = 4'd0,
      SLOT_SGR_ESC       = 4'd1,
      SLOT_SGR_BRACKET   = 4'd2,
      SLOT_SGR_STYLE     = 4'd3,
      SLOT_FG_SEMI       = 4'd4,
      SLOT_FG_TENS       = 4'd5,
      SLOT_FG_UNITS      = 4'd6,
      SLOT_BG_SEMI       = 4'd7,
      SLOT_BG_TENS       = 4'd8,
      SLOT_BG_UNITS      = 4'd9,
      SLOT_SGR_M         = 4'd10,
      SLOT_CLOSE_ESC     = 4'd11,
      SLOT_CLOSE_BRACKET = 4'd12,
      SLOT_CLOSE_ZERO    = 4'd13,
      SLOT_CLOSE_M       = 4'd14
   } slot_type;

   typedef struct packed {
      logic [2:0] style;
      logic [5:0] fore;
      logic [5:0] back;
   } codes_type;

   // One classified input: what the back part has to write for it.
   typedef struct packed {
      logic       text_en;
      logic [7:0] text_byte;
      logic       sgr_en;
      codes_type  codes;
      logic       close_en;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Applies one finished parameter to the current codes.
   function automatic codes_type classify(logic [7:0] value, codes_type cur);
      codes_type res;
      res = cur;
      if (value <= STYLE_MAX) begin
         res.style = value[2:0];
      end else if (value >= FG_LO && value <= FG_HI) begin
         res.fore = value[5:0];
      end else if (value >= BG_LO && value <= BG_HI) begin
         res.back = value[5:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[rtl/asef_front.sv]
// Front part of the SGR escape filter: parses input bytes and emits commands.
// Depends on asef_pkg.
`default_nettype none

module asef_front
   import asef_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] char_byte,
   input  wire logic       end_of_text,
   output      logic       cmd_push,
   output      cmd_type    cmd
);

   parse_mode_type mode_ff, mode_in;
   logic [7:0]     accum_ff, accum_in;
   codes_type      codes_ff, codes_in;

   logic        is_digit, is_semi, is_final, param_path;
   logic [11:0] acc_wide;
   codes_type   classified;

   assign is_digit = (char_byte >= ZERO_CHAR) && (char_byte <= NINE_CHAR);
   assign is_semi  = (char_byte == SEMI_CHAR);
   assign is_final = (char_byte >= FINAL_LO) && (char_byte <= FINAL_HI);
   assign acc_wide = 12'(accum_ff) * 12'd10 + 12'(char_byte - ZERO_CHAR);
   assign classified = classify(accum_ff, codes_ff);

   // A byte goes through parameter handling unless it is text, or the '['
   // that directly follows ESC.
   always_comb begin
      param_path = 1'b0;
      unique case (mode_ff)
         MODE_TEXT:      param_path = 1'b0;
         MODE_AFTER_ESC: param_path = (char_byte != BRACKET_CHAR);
         default:        param_path = 1'b1;
      endcase
   end

   // Next parse mode.
   always_comb begin
      mode_in = mode_ff;
      unique case (mode_ff)
         MODE_TEXT: begin
            if (char_byte == ESC_CHAR) mode_in = MODE_AFTER_ESC;
         end
         MODE_AFTER_ESC: begin
            mode_in = MODE_PARAMS;
            if (param_path && is_final) mode_in = MODE_TEXT;
         end
         default: begin
            if (is_final) mode_in = MODE_TEXT;
         end
      endcase
      if (end_of_text) mode_in = MODE_TEXT;
   end

   // Parameter datapath and command.
   always_comb begin
      accum_in = accum_ff;
      codes_in = codes_ff;
      cmd      = '0;
      if (mode_ff == MODE_TEXT) begin
         if (char_byte == ESC_CHAR) begin
            accum_in = '0;
            codes_in = '0;
         end else begin
            cmd.text_en   = 1'b1;
            cmd.text_byte = char_byte;
         end
      end else if (param_path) begin
         if (is_digit) begin
            accum_in = (acc_wide > 12'(ACCUM_MAX)) ? ACCUM_MAX : acc_wide[7:0];
         end else if (is_semi) begin
            codes_in = classified;
            accum_in = '0;
         end else if (is_final) begin
            codes_in = classified;
            accum_in = '0;
            if (char_byte == M_CHAR) begin
               cmd.sgr_en = 1'b1;
               cmd.codes  = classified;
            end
         end
      end
      if (end_of_text) begin
         accum_in     = '0;
         cmd.close_en = 1'b1;
      end
   end

   assign cmd_push = accept && (cmd.text_en || cmd.sgr_en || cmd.close_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_TEXT;
         accum_ff <= '0;
         codes_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         accum_ff <= accum_in;
         codes_ff <= codes_in;
      end
   end

endmodule

`default_nettype wire

[rtl/asef_queue.sv]
// Short command queue between the front and back parts of the SGR filter.
// Depends on asef_pkg.
`default_nettype none

module asef_queue
   import asef_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire cmd_type    push_cmd,
   input  wire logic       pop,
   output      cmd_type    head_cmd,
   output queue_status_type status
);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

`default_nettype wire

[rtl/asef_back.sv]
// Back part of the SGR filter: expands queued commands into output bytes.
// Depends on asef_pkg.
`default_nettype none

module asef_back
   import asef_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          head_cmd,
   input  wire queue_status_type q_status,
   output      logic             q_pop,
   input  wire logic             rsp_pop,
   output      logic             rsp_empty,
   output      logic [7:0]       rsp_out_byte,
   output      logic             rsp_run_last,
   output      logic             rsp_text_done
);

   logic [NUM_SLOTS-1:0] done_ff, done_in;
   logic [NUM_SLOTS-1:0] enable, remaining, cur_bit;
   slot_type             cur;
   logic                 last_slot, load;
   logic [5:0]           fg_diff, bg_diff;
   logic [7:0]           byte_sel;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_last_ff, out_done_ff;

   always_comb begin
      enable = '0;
      enable[SLOT_TEXT]          = head_cmd.text_en;
      enable[SLOT_SGR_ESC]       = head_cmd.sgr_en;
      enable[SLOT_SGR_BRACKET]   = head_cmd.sgr_en;
      enable[SLOT_SGR_STYLE]     = head_cmd.sgr_en;
      enable[SLOT_FG_SEMI]       = head_cmd.sgr_en && (head_cmd.codes.fore != '0);
      enable[SLOT_FG_TENS]       = head_cmd.sgr_en && (head_cmd.codes.fore != '0);
      enable[SLOT_FG_UNITS]      = head_cmd.sgr_en && (head_cmd.codes.fore != '0);
      enable[SLOT_BG_SEMI]       = head_cmd.sgr_en && (head_cmd.codes.back != '0);
      enable[SLOT_BG_TENS]       = head_cmd.sgr_en && (head_cmd.codes.back != '0);
      enable[SLOT_BG_UNITS]      = head_cmd.sgr_en && (head_cmd.codes.back != '0);
      enable[SLOT_SGR_M]         = head_cmd.sgr_en;
      enable[SLOT_CLOSE_ESC]     = head_cmd.close_en;
      enable[SLOT_CLOSE_BRACKET] = head_cmd.close_en;
      enable[SLOT_CLOSE_ZERO]    = head_cmd.close_en;
      enable[SLOT_CLOSE_M]       = head_cmd.close_en;
   end

   assign remaining = enable & ~done_ff;

   // Lowest remaining slot is the next byte to write.
   always_comb begin
      cur = SLOT_TEXT;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (remaining[i]) cur = slot_type'(4'(i));
      end
   end

   assign cur_bit   = NUM_SLOTS'(1) << cur;
   assign last_slot = ((remaining & ~cur_bit) == '0);
   assign fg_diff   = head_cmd.codes.fore - FG_LO[5:0];
   assign bg_diff   = head_cmd.codes.back - BG_LO[5:0];

   always_comb begin
      byte_sel = ESC_CHAR;
      unique case (cur)
         SLOT_TEXT:          byte_sel = head_cmd.text_byte;
         SLOT_SGR_ESC:       byte_sel = ESC_CHAR;
         SLOT_SGR_BRACKET:   byte_sel = BRACKET_CHAR;
         SLOT_SGR_STYLE:     byte_sel = ZERO_CHAR + 8'(head_cmd.codes.style);
         SLOT_FG_SEMI:       byte_sel = SEMI_CHAR;
         SLOT_FG_TENS:       byte_sel = FG_TENS_CHAR;
         SLOT_FG_UNITS:      byte_sel = ZERO_CHAR + 8'(fg_diff[2:0]);
         SLOT_BG_SEMI:       byte_sel = SEMI_CHAR;
         SLOT_BG_TENS:       byte_sel = BG_TENS_CHAR;
         SLOT_BG_UNITS:      byte_sel = ZERO_CHAR + 8'(bg_diff[2:0]);
         SLOT_SGR_M:         byte_sel = M_CHAR;
         SLOT_CLOSE_ESC:     byte_sel = ESC_CHAR;
         SLOT_CLOSE_BRACKET: byte_sel = BRACKET_CHAR;
         SLOT_CLOSE_ZERO:    byte_sel = ZERO_CHAR;
         SLOT_CLOSE_M:       byte_sel = M_CHAR;
         default:            byte_sel = ESC_CHAR;
      endcase
   end

   assign load         = !q_status.empty && (!out_valid_ff || rsp_pop);
   assign q_pop        = load && last_slot;
   assign out_valid_in = load || (out_valid_ff && !rsp_pop);

   always_comb begin
      done_in = done_ff;
      if (load) done_in = last_slot ? '0 : (done_ff | cur_bit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= byte_sel;
         out_last_ff <= last_slot;
         out_done_ff <= (cur == SLOT_CLOSE_M);
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_run_last  = out_last_ff;
   assign rsp_text_done = out_done_ff;

endmodule

`default_nettype wire

[rtl/ansi_sgr_escape_filter.sv]
// Top level of the ANSI SGR escape filter: front parser, command queue, back expander.
// Depends on asef_pkg, asef_front, asef_queue, asef_back and assert_macros.svh.
//
// Usage: text bytes enter on the req_ channel, which behaves like the write
// side of a queue. A transaction is taken on a clock edge where req_push is
// high and req_full is low; req_end_of_text marks the final byte of a text.
// Output bytes leave on the rsp_ channel, which behaves like the read side of
// a queue: while rsp_empty is low the oldest byte is on rsp_out_byte, and it
// is taken on an edge where rsp_pop is high.
// Ordinary text passes through byte for byte, so a plain byte stream runs at one
// transaction per cycle in both directions while nothing stalls. A byte taken on
// req_ goes into the command queue and then the output register before it reaches
// the rsp_ ports. A final 'm' expands into 4 to 10 bytes and the end of text
// adds 4 more, up to 14 in all; the back end writes one byte per cycle while the
// receiver pops; the front takes input until the two-entry command queue fills.
// If the receiver stalls, the output register holds its byte, the queue fills
// and req_full rises; nothing is lost. Bytes that only change parser state
// (ESC, parameters, dropped sequences) produce no output at all.
// A synchronous reset returns the parser to text mode with cleared
// parameters and empties the queue and the output register.
`default_nettype none
`include "assert_macros.svh"

module ansi_sgr_escape_filter
   import asef_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output      logic       req_full,
   input  wire logic [7:0] req_char_byte,
   input  wire logic       req_end_of_text,
   output      logic       rsp_empty,
   input  wire logic       rsp_pop,
   output      logic [7:0] rsp_out_byte,
   output      logic       rsp_run_last,
   output      logic       rsp_text_done
);

   logic             accept;
   logic             cmd_push;
   cmd_type          cmd;
   cmd_type          head_cmd;
   logic             q_pop;
   queue_status_type q_status;

   // The front only advances when the queue has room for its command.
   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   asef_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_byte   (req_char_byte),
      .end_of_text (req_end_of_text),
      .cmd_push    (cmd_push),
      .cmd         (cmd)
   );

   asef_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   asef_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_cmd      (head_cmd),
      .q_status      (q_status),
      .q_pop         (q_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_text_done (rsp_text_done)
   );

   // The closing reset sequence always ends the output of its transaction.
   `ASSERT_IMPLIES(a_done_is_last, clock, reset, !rsp_empty && rsp_text_done, rsp_run_last)
   // A full queue cannot also be empty.
   `ASSERT_IMPLIES(a_queue_sane, clock, reset, q_status.full, !q_status.empty)
   // Reset leaves nothing on the output side.
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty && !q_status.full)
   // The queue is only drained when the back end has something to take.
   `ASSERT_IMPLIES(a_pop_nonempty, clock, reset, q_pop, !q_status.empty)

endmodule

`default_nettype wire

[tb/sgr_stream_checker.sv]
// Scoreboard for the SGR escape filter: predicts the output byte stream and compares it.
// Depends on asef_pkg for the parse mode enum and the character constants.
`default_nettype none

module sgr_stream_checker
   import asef_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   input  wire logic       req_full,
   input  wire logic [7:0] req_char_byte,
   input  wire logic       req_end_of_text,
   input  wire logic       rsp_empty,
   input  wire logic       rsp_pop,
   input  wire logic [7:0] rsp_out_byte,
   input  wire logic       rsp_run_last,
   input  wire logic       rsp_text_done,
   output int              mismatch_count,
   output int              outstanding_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       text_done;
   } out_beat_type;

   out_beat_type   expected_bytes[$];
   parse_mode_type mode;
   logic [7:0]     accum;
   logic [2:0]     style;
   logic [5:0]     fore;
   logic [5:0]     back;

   function automatic out_beat_type beat(input logic [7:0] data);
      out_beat_type b;
      b.data = data;
      b.run_last = 1'b0;
      b.text_done = 1'b0;
      return b;
   endfunction

   function automatic void apply_param();
      if (accum <= STYLE_MAX) begin
         style = accum[2:0];
      end else if (accum >= FG_LO && accum <= FG_HI) begin
         fore = accum[5:0];
      end else if (accum >= BG_LO && accum <= BG_HI) begin
         back = accum[5:0];
      end
   endfunction

   // Advances the parser by one input byte and queues the bytes it writes.
   task automatic filter_byte(input logic [7:0] c, input logic eot);
      out_beat_type beats[$];
      int           acc;
      logic         param_path;
      param_path = 1'b0;
      case (mode)
         MODE_TEXT: begin
            if (c == ESC_CHAR) begin
               mode = MODE_AFTER_ESC;
               accum = '0;
               style = '0;
               fore = '0;
               back = '0;
            end else begin
               beats.push_back(beat(c));
            end
         end
         MODE_AFTER_ESC: begin
            mode = MODE_PARAMS;
            param_path = (c != BRACKET_CHAR);
         end
         default: begin
            param_path = 1'b1;
         end
      endcase
      if (param_path) begin
         if (c >= ZERO_CHAR && c <= NINE_CHAR) begin
            acc = int'(accum) * 10 + int'(c) - int'(ZERO_CHAR);
            accum = (acc > int'(ACCUM_MAX)) ? ACCUM_MAX : 8'(acc);
         end else if (c == SEMI_CHAR) begin
            apply_param();
            accum = '0;
         end else if (c >= FINAL_LO && c <= FINAL_HI) begin
            apply_param();
            if (c == M_CHAR) begin
               beats.push_back(beat(ESC_CHAR));
               beats.push_back(beat(BRACKET_CHAR));
               beats.push_back(beat(8'(ZERO_CHAR + style)));
               if (fore != 0) begin
                  beats.push_back(beat(SEMI_CHAR));
                  beats.push_back(beat(8'(ZERO_CHAR + fore / 10)));
                  beats.push_back(beat(8'(ZERO_CHAR + fore % 10)));
               end
               if (back != 0) begin
                  beats.push_back(beat(SEMI_CHAR));
                  beats.push_back(beat(8'(ZERO_CHAR + back / 10)));
                  beats.push_back(beat(8'(ZERO_CHAR + back % 10)));
               end
               beats.push_back(beat(M_CHAR));
            end
            mode = MODE_TEXT;
            accum = '0;
         end
      end
      if (eot) begin
         mode = MODE_TEXT;
         accum = '0;
         beats.push_back(beat(ESC_CHAR));
         beats.push_back(beat(BRACKET_CHAR));
         beats.push_back(beat(ZERO_CHAR));
         beats.push_back(beat(M_CHAR));
         beats[beats.size() - 1].text_done = 1'b1;
      end
      if (beats.size() > 0) begin
         beats[beats.size() - 1].run_last = 1'b1;
      end
      foreach (beats[i]) begin
         expected_bytes.push_back(beats[i]);
      end
   endtask

   task automatic compare_byte();
      out_beat_type want;
      if (expected_bytes.size() == 0) begin
         if (mismatch_count < 10) begin
            $display("unexpected output byte %02h at %0t with nothing pending",
                     rsp_out_byte, $realtime);
         end
         mismatch_count++;
      end else begin
         want = expected_bytes.pop_front();
         if (want.data !== rsp_out_byte || want.run_last !== rsp_run_last ||
             want.text_done !== rsp_text_done) begin
            if (mismatch_count < 10) begin
               $display("mismatch at %0t: expected byte %02h last %0b done %0b, got %02h %0b %0b",
                        $realtime, want.data, want.run_last, want.text_done,
                        rsp_out_byte, rsp_run_last, rsp_text_done);
            end
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode = MODE_TEXT;
         accum = '0;
         style = '0;
         fore = '0;
         back = '0;
         expected_bytes.delete();
      end else begin
         if (req_push && !req_full) begin
            filter_byte(req_char_byte, req_end_of_text);
         end
         if (rsp_pop && !rsp_empty) begin
            compare_byte();
         end
      end
      outstanding_count = expected_bytes.size();
   end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Top of the SGR escape filter testbench: clock, reset, stimulus, watchdog and verdict.
// Depends on asef_pkg, the ansi_sgr_escape_filter RTL and sgr_stream_checker.
`default_nettype none

module tb_top
   import asef_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // A run must keep moving: this many cycles without any transaction on
   // either channel means the block has hung.
   localparam int STALL_LIMIT = 400;
   localparam int RANDOM_ITEMS = 460;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_char_byte;
   logic       req_end_of_text;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       rsp_text_done;

   int   mismatch_count;
   int   outstanding_count;
   int   sent_count;
   int   quiet_cycles;
   // While set, neither side inserts idle cycles.
   logic no_idle;

   ansi_sgr_escape_filter uut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_char_byte   (req_char_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_text_done   (rsp_text_done)
   );

   sgr_stream_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_char_byte     (req_char_byte),
      .req_end_of_text   (req_end_of_text),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_run_last      (rsp_run_last),
      .rsp_text_done     (rsp_text_done),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Sends one byte as a transaction. The task is entered and left at a
   // falling edge; on return push is still high so that a following byte
   // keeps the channel busy without a bubble.
   task automatic send_char(input logic [7:0] c, input logic eot);
      while (!no_idle && $urandom_range(0, 99) < 24) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_char_byte <= c;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_full);
      sent_count++;
      @(negedge clock);
   endtask

   // Sends a string byte by byte; the end-of-text flag goes on its last byte only.
   task automatic send_text(input string s, input logic eot_last);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], eot_last && (i == s.len() - 1));
      end
   endtask

   // Holds the sender back until every predicted byte has been read out.
   // At least one falling edge passes, so push gets one assignment per step.
   task automatic drain_results();
      req_push <= 1'b0;
      do @(negedge clock); while (outstanding_count != 0);
   endtask

   // Receiver: pop is redrawn at each falling edge; it stalls about a quarter
   // of the time except during the calm stretch.
   initial begin
      rsp_pop = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         rsp_pop <= no_idle || ($urandom_range(0, 99) >= 24);
      end
   end

   // Watchdog: counts cycles in which no transaction moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      int         kind;
      int         n;
      int         v;
      logic [7:0] c;

      reset = 1'b1;
      req_push = 1'b0;
      req_char_byte = '0;
      req_end_of_text = 1'b0;
      no_idle = 1'b0;
      sent_count = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Plain text at both ends of the byte range, the zero
      // byte included.
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      // Full sequence with style, foreground and background at their upper
      // limits, ending the text: the longest expansion the block can produce.
      send_text("\033[4;37;47m", 1'b1);
      // No bracket after ESC, and a parameter that overflows and saturates
      // to an unclassified value: only the style digit 0 comes out.
      send_text("\033999m", 1'b0);
      // Empty parameter, an ESC inside the sequence that must be ignored, and
      // a late bracket that acts as a non-m final byte and drops everything.
      send_text("\033[;\033[", 1'b0);
      // Sequence still open when the text ends: dropped, reset still appended.
      send_text("\033[31", 1'b1);

      // Let everything drain once before the random traffic starts.
      drain_results();

      while (sent_count < RANDOM_ITEMS) begin
         no_idle = (sent_count >= 180 && sent_count < 280);
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            // A run of plain text. ESC is moved away so the run stays text.
            n = $urandom_range(1, 6);
            repeat (n) begin
               c = 8'($urandom_range(0, 255));
               if (c == ESC_CHAR) begin
                  c = c ^ 8'h40;
               end
               send_char(c, $urandom_range(0, 99) < 2);
            end
         end else if (kind < 80) begin
            // A mostly well-formed SGR sequence with random parameters.
            send_char(ESC_CHAR, 1'b0);
            if ($urandom_range(0, 9) != 0) begin
               send_char(BRACKET_CHAR, 1'b0);
            end
            n = $urandom_range(1, 4);
            for (int j = 0; j < n; j++) begin
               if (j > 0) begin
                  send_char(SEMI_CHAR, 1'b0);
               end
               kind = $urandom_range(0, 9);
               if (kind < 3) begin
                  v = $urandom_range(0, 4);
               end else if (kind < 6) begin
                  v = $urandom_range(FG_LO, FG_HI);
               end else if (kind < 9) begin
                  v = $urandom_range(BG_LO, BG_HI);
               end else begin
                  v = $urandom_range(0, 999);
               end
               // Now and then the parameter is left empty.
               if ($urandom_range(0, 19) != 0) begin
                  if (v >= 100) begin
                     send_char(8'(ZERO_CHAR + v / 100), 1'b0);
                  end
                  if (v >= 10) begin
                     send_char(8'(ZERO_CHAR + (v / 10) % 10), 1'b0);
                  end
                  send_char(8'(ZERO_CHAR + v % 10), 1'b0);
               end
            end
            c = ($urandom_range(0, 99) < 85) ? M_CHAR
                                              : 8'($urandom_range(FINAL_LO, FINAL_HI));
            send_char(c, $urandom_range(0, 99) < 8);
         end else if (kind < 95) begin
            // Unrestricted noise bytes, ESC among them.
            n = $urandom_range(1, 5);
            repeat (n) begin
               send_char(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 3);
            end
         end else begin
            // A broken sequence, often cut off by the end of the text.
            send_char(ESC_CHAR, 1'b0);
            n = $urandom_range(1, 4);
            for (int j = 0; j < n; j++) begin
               kind = $urandom_range(0, 2);
               if (kind == 0) begin
                  c = 8'(ZERO_CHAR + $urandom_range(0, 9));
               end else if (kind == 1) begin
                  c = SEMI_CHAR;
               end else begin
                  c = 8'($urandom_range(0, 255));
               end
               send_char(c, (j == n - 1) && ($urandom_range(0, 1) == 1));
            end
         end
         if ($urandom_range(0, 39) == 0) begin
            drain_results();
         end
      end
      no_idle = 1'b0;

      // All transactions are in; wait for the last bytes, then a short settle
      // so that any stray extra output would still be caught.
      drain_results();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && outstanding_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/asef_pkg.sv
rtl/asef_front.sv
rtl/asef_queue.sv
rtl/asef_back.sv
rtl/ansi_sgr_escape_filter.sv
tb/sgr_stream_checker.sv
tb/tb_top.sv
